// ----- design/gws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gws_pkg: shared types and constants of the gaussian window smoother
// widths of the payload fields, register indexes and reset weights
// ----------------------------------------------------------------------------
package gws_pkg;

   localparam int KERNEL_SIZE = 3;
   localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;

   localparam int SAMPLE_W    = 16;
   localparam int WEIGHT_W    = 20;
   localparam int COLS_REG_W  = 11;
   localparam int ROWS_REG_W  = 16;
   localparam int ROW_CNT_W   = ROWS_REG_W + 1;
   localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
   localparam int ROWSUM_W    = PROD_W + 2;
   localparam int SUM_W       = PROD_W + 4;
   localparam int FRAC_W      = 16;
   localparam int CSR_INDEX_W = 3;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] REG_WEIGHT_CENTER = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WEIGHT_EDGE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WEIGHT_CORNER = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_COLS    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_ROWS    = 3'd4;

   // command codes of the request word
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   localparam logic [WEIGHT_W-1:0]   RESET_WEIGHT_CENTER = 20'd41721;
   localparam logic [WEIGHT_W-1:0]   RESET_WEIGHT_EDGE   = 20'd5646;
   localparam logic [WEIGHT_W-1:0]   RESET_WEIGHT_CORNER = 20'd764;
   localparam logic [COLS_REG_W-1:0] RESET_IMAGE_COLS    = 11'd1024;
   localparam logic [ROWS_REG_W-1:0] RESET_IMAGE_ROWS    = 16'd1024;

   typedef logic [SAMPLE_W-1:0] gws_sample_type;

   // tap t sits at row t / 3, column t % 3 of the window
   typedef logic [TAPS-1:0][SAMPLE_W-1:0] gws_window_type;

   // which neighbours of the centre pixel lie inside the image, and whether it is the last pixel
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic last;
   } gws_bounds_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] center;
      logic [WEIGHT_W-1:0] side;
      logic [WEIGHT_W-1:0] corner;
   } gws_weights_type;

endpackage

// ----- design/gaussian_window_smoother.sv -----
`timescale 1ns / 1ps
// the word that completes a window passes the stage 1, stage 2, product, row sum and
//    output registers; it arrives image_cols + 1 words after the centre sample
// throughput: one word per cycle while rsp_ready is high; one shared stall follows rsp_ready
// reset: synchronous, active high; clears position, window and valid bits, restores the
//    register defaults; line store contents stay undefined until written
// ----------------------------------------------------------------------------
// gaussian_window_smoother: 3x3 gaussian blur over a raster stream
// line stores in one synchronous memory, window shifter, multiply-add pipeline
// ----------------------------------------------------------------------------
module gaussian_window_smoother #(
   parameter int MAX_COLS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [gws_pkg::SAMPLE_W-1:0]      req_sample_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gws_pkg::SAMPLE_W-1:0]      rsp_smoothed_value,
   output logic                              rsp_saturated,
   output logic                              rsp_last_pixel,
   input  logic                              csr_write_enable,
   input  logic [gws_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gws_pkg::WEIGHT_W-1:0]      csr_write_data
);
   import gws_pkg::*;

   localparam int IDX_W = $clog2(MAX_COLS);

   // configuration registers
   logic [WEIGHT_W-1:0]   weight_center_ff, weight_edge_ff, weight_corner_ff;
   logic [COLS_REG_W-1:0] image_cols_ff;
   logic [ROWS_REG_W-1:0] image_rows_ff;
   gws_weights_type       weights;

   // handshake and shared stall
   logic adv;
   logic req_fire;

   // position of the incoming word
   logic [IDX_W-1:0] pos_idx;
   logic             pos_emit;
   gws_bounds_type   pos_bounds;
   gws_sample_type   sample_in;

   // stage 1: line store data back, read-modify-write
   logic                    s1_valid_ff;
   logic                    s1_emit_ff;
   gws_bounds_type          s1_bounds_ff;
   logic [IDX_W-1:0]        s1_idx_ff;
   gws_sample_type          s1_sample_ff;
   logic                    s1_fwd_ff, s1_fwd_in;
   logic [2*SAMPLE_W-1:0]   s1_fwd_data_ff;
   logic [2*SAMPLE_W-1:0]   rd_data, stored;
   gws_sample_type          upper_eff, middle_eff;
   logic                    wr_en;
   logic [2*SAMPLE_W-1:0]   wr_data;

   // stage 2: window and its bounds
   gws_window_type  window_ff, window_in;
   logic            s2_valid_ff;
   gws_bounds_type  s2_bounds_ff;

   // multiply-add pipeline and output register
   logic            mac_valid, mac_saturated, mac_last;
   gws_sample_type  mac_value;
   logic            rsp_valid_ff;
   gws_sample_type  rsp_value_ff;
   logic            rsp_saturated_ff, rsp_last_ff;

   // ------------------------------------------------------------------------
   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_center_ff <= RESET_WEIGHT_CENTER;
         weight_edge_ff   <= RESET_WEIGHT_EDGE;
         weight_corner_ff <= RESET_WEIGHT_CORNER;
         image_cols_ff    <= RESET_IMAGE_COLS;
         image_rows_ff    <= RESET_IMAGE_ROWS;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_WEIGHT_CENTER: weight_center_ff <= csr_write_data;
            REG_WEIGHT_EDGE:   weight_edge_ff   <= csr_write_data;
            REG_WEIGHT_CORNER: weight_corner_ff <= csr_write_data;
            REG_IMAGE_COLS:    image_cols_ff    <= csr_write_data[COLS_REG_W-1:0];
            REG_IMAGE_ROWS:    image_rows_ff    <= csr_write_data[ROWS_REG_W-1:0];
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   assign weights.center = weight_center_ff;
   assign weights.side   = weight_edge_ff;
   assign weights.corner = weight_corner_ff;

   // ------------------------------------------------------------------------
   // the whole pipe moves when the output register is free or being drained
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign req_fire  = req_valid && req_ready;

   // a flush word pushes a zero sample
   assign sample_in = (req_command == CMD_FLUSH) ? '0 : req_sample_value;

   gws_position #(
      .MAX_COLS (MAX_COLS),
      .IDX_W    (IDX_W)
   ) u_position (
      .clock      (clock),
      .reset      (reset),
      .step       (req_fire),
      .image_cols (image_cols_ff),
      .image_rows (image_rows_ff),
      .idx        (pos_idx),
      .emit       (pos_emit),
      .bounds     (pos_bounds)
   );

   // line store read on accept, written back from the stage 1 registers when the pipe moves
   gws_line_store #(
      .DEPTH  (MAX_COLS),
      .ADDR_W (IDX_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (pos_idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (wr_data)
   );

   // ------------------------------------------------------------------------
   // stage 1: the read of the new word races the write-back of the word ahead
   // of it; with a narrow image both hit the same column, so the written
   // word is caught and used instead of the stale read
   always_comb begin
      stored     = s1_fwd_ff ? s1_fwd_data_ff : rd_data;
      upper_eff  = stored[2*SAMPLE_W-1:SAMPLE_W];
      middle_eff = stored[SAMPLE_W-1:0];
      wr_en      = s1_valid_ff && adv;
      // the middle row moves up, the new sample becomes the middle row
      wr_data    = {middle_eff, s1_sample_ff};
      s1_fwd_in  = s1_valid_ff && (s1_idx_ff == pos_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_emit_ff     <= pos_emit;
         s1_bounds_ff   <= pos_bounds;
         s1_idx_ff      <= pos_idx;
         s1_sample_ff   <= sample_in;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= wr_data;
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: window shifts one column left, new right column from the stores and the new sample
   always_comb begin
      window_in = window_ff;
      for (int k = 0; k < KERNEL_SIZE; k++) begin
         window_in[k*KERNEL_SIZE]     = window_ff[k*KERNEL_SIZE + 1];
         window_in[k*KERNEL_SIZE + 1] = window_ff[k*KERNEL_SIZE + 2];
      end
      window_in[KERNEL_SIZE - 1]   = upper_eff;
      window_in[2*KERNEL_SIZE - 1] = middle_eff;
      window_in[TAPS - 1]          = s1_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         if (s1_valid_ff) begin
            window_ff <= window_in;
         end
         // only words that complete a window go on to the sum
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_bounds_ff <= s1_bounds_ff;
      end
   end

   gws_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .enable        (adv),
      .in_valid      (s2_valid_ff),
      .in_bounds     (s2_bounds_ff),
      .in_window     (window_ff),
      .weights       (weights),
      .out_valid     (mac_valid),
      .out_value     (mac_value),
      .out_saturated (mac_saturated),
      .out_last      (mac_last)
   );

   // ------------------------------------------------------------------------
   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mac_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && mac_valid) begin
         rsp_value_ff     <= mac_value;
         rsp_saturated_ff <= mac_saturated;
         rsp_last_ff      <= mac_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smoothed_value = rsp_value_ff;
   assign rsp_saturated      = rsp_saturated_ff;
   assign rsp_last_pixel     = rsp_last_ff;

`ifndef SYNTHESIS
   // a saturated word always carries the clipped maximum
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_smoothed_value == '1))
      else $error("saturated word without clipped value");

   // the word that ends the image restarts the raster at column zero
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && pos_emit && pos_bounds.last) |=> (pos_idx == '0))
      else $error("raster position not cleared after last pixel");

   // a stalled word in stage 1 keeps its column
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> (s1_valid_ff && $stable(s1_idx_ff)))
      else $error("stage 1 word lost under stall");

   // a blocked response word stops intake
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while output blocked");

   // the column counter never leaves the line store
   assert property (@(posedge clock) disable iff (reset)
      32'(pos_idx) < MAX_COLS)
      else $error("column index beyond line store");
`endif

endmodule

// ----- design/gws_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gws_line_store: the two line stores, one word per column
// upper and middle row kept side by side, registered read
// ----------------------------------------------------------------------------
module gws_line_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [2*gws_pkg::SAMPLE_W-1:0] rd_data,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [2*gws_pkg::SAMPLE_W-1:0] wr_data
);
   import gws_pkg::*;

   localparam int DATA_W = 2 * SAMPLE_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/gws_position.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gws_position: raster position of the incoming word
// column and row counters, window centre bounds and end of image
// ----------------------------------------------------------------------------
module gws_position #(
   parameter int MAX_COLS = 1024,
   parameter int IDX_W    = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [gws_pkg::COLS_REG_W-1:0]  image_cols,
   input  logic [gws_pkg::ROWS_REG_W-1:0]  image_rows,
   output logic [IDX_W-1:0]                idx,
   output logic                            emit,
   output gws_pkg::gws_bounds_type         bounds
);
   import gws_pkg::*;

   localparam int CNT_W = $clog2(MAX_COLS + 1);

   logic [IDX_W-1:0]     col_ff, col_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0]     cols_eff, col_next, ccol;
   logic [ROW_CNT_W-1:0] rows_eff, crow;
   logic                 first_col;

   always_comb begin
      if (image_cols == '0) begin
         cols_eff = CNT_W'(1);
      end else if (32'(image_cols) > MAX_COLS) begin
         cols_eff = CNT_W'(MAX_COLS);
      end else begin
         cols_eff = CNT_W'(image_cols);
      end
      rows_eff = (image_rows == '0) ? ROW_CNT_W'(1) : ROW_CNT_W'(image_rows);
   end

   always_comb begin
      first_col = (col_ff == '0);
      col_next  = CNT_W'(col_ff) + CNT_W'(1);
      // centre of the window lags one row and one column, so at a row start it sits two rows back
      emit = first_col ? (row_ff >= ROW_CNT_W'(2)) : (row_ff >= ROW_CNT_W'(1));
      ccol = first_col ? (cols_eff - CNT_W'(1)) : (CNT_W'(col_ff) - CNT_W'(1));
      crow = first_col ? (row_ff - ROW_CNT_W'(2)) : (row_ff - ROW_CNT_W'(1));
      bounds.top    = (crow != '0);
      bounds.bottom = ((crow + ROW_CNT_W'(1)) < rows_eff);
      bounds.left   = (ccol != '0);
      bounds.right  = ((ccol + CNT_W'(1)) < cols_eff);
      bounds.last   = !bounds.bottom && !bounds.right;
   end

   always_comb begin
      if (col_next >= cols_eff) begin
         col_in = '0;
         row_in = row_ff + ROW_CNT_W'(1);
      end else begin
         col_in = col_next[IDX_W-1:0];
         row_in = row_ff;
      end
      if (emit && bounds.last) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (step) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign idx = col_ff;

endmodule

// ----- design/gws_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gws_mac: weighted window sum
// nine product lanes, registered row sums, final add with saturation
// ----------------------------------------------------------------------------
module gws_mac (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           in_valid,
   input  gws_pkg::gws_bounds_type        in_bounds,
   input  gws_pkg::gws_window_type        in_window,
   input  gws_pkg::gws_weights_type       weights,
   output logic                           out_valid,
   output logic [gws_pkg::SAMPLE_W-1:0]   out_value,
   output logic                           out_saturated,
   output logic                           out_last
);
   import gws_pkg::*;

   localparam int Q_W = SUM_W - FRAC_W;

   logic [TAPS-1:0][PROD_W-1:0]           prod_in, prod_ff;
   logic [KERNEL_SIZE-1:0][ROWSUM_W-1:0]  rowsum_in, rowsum_ff;
   logic                                  valid_a_ff, valid_b_ff;
   logic                                  last_a_ff, last_b_ff;
   logic [SUM_W-1:0]                      total;
   logic [Q_W-1:0]                        quotient;

   for (genvar t = 0; t < TAPS; t++) begin : g_lane
      localparam int R    = t / KERNEL_SIZE;
      localparam int C    = t % KERNEL_SIZE;
      localparam int RING = (R != 1 ? 1 : 0) + (C != 1 ? 1 : 0);
      logic                row_ok, col_ok, lane_on;
      logic [WEIGHT_W-1:0] lane_weight;
      always_comb begin
         row_ok  = (R == 0) ? in_bounds.top  : ((R == 2) ? in_bounds.bottom : 1'b1);
         col_ok  = (C == 0) ? in_bounds.left : ((C == 2) ? in_bounds.right  : 1'b1);
         lane_on = row_ok && col_ok;
         if (RING == 0) begin
            lane_weight = weights.center;
         end else if (RING == 1) begin
            lane_weight = weights.side;
         end else begin
            lane_weight = weights.corner;
         end
         // a tap outside the image adds nothing, whatever the stored word holds
         prod_in[t] = lane_on ? PROD_W'(in_window[t]) * PROD_W'(lane_weight) : '0;
      end
   end

   for (genvar r = 0; r < KERNEL_SIZE; r++) begin : g_row
      assign rowsum_in[r] = ROWSUM_W'(prod_ff[r*KERNEL_SIZE])
                          + ROWSUM_W'(prod_ff[r*KERNEL_SIZE+1])
                          + ROWSUM_W'(prod_ff[r*KERNEL_SIZE+2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff   <= prod_in;
         last_a_ff <= in_bounds.last;
         rowsum_ff <= rowsum_in;
         last_b_ff <= last_a_ff;
      end
   end

   always_comb begin
      total = SUM_W'(rowsum_ff[0]) + SUM_W'(rowsum_ff[1]) + SUM_W'(rowsum_ff[2]);
      quotient      = total[SUM_W-1:FRAC_W];
      out_saturated = |quotient[Q_W-1:SAMPLE_W];
      out_value     = out_saturated ? '1 : quotient[SAMPLE_W-1:0];
   end

   assign out_valid = valid_b_ff;
   assign out_last  = last_b_ff;

endmodule

// ----- dv/gaussian_window_smoother_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_window_smoother_test: self-checking bench of the 3x3 gaussian blur
// streams images of many shapes and weight settings through the block, keeps a
// cycle-free model of the line stores and window, and checks every response
// word against the blurred pixel it predicts, with random idling on both sides
// ----------------------------------------------------------------------------

localparam int LINE_DEPTH = 1024;

typedef struct packed {
   logic [15:0] value;
   logic        saturated;
   logic        last_pixel;
} smoothed_pixel_type;

typedef struct packed {
   logic        command;
   logic [15:0] sample;
} request_word_type;

class pixel_scoreboard;
   logic [gws_pkg::WEIGHT_W-1:0]   w_center;
   logic [gws_pkg::WEIGHT_W-1:0]   w_side;
   logic [gws_pkg::WEIGHT_W-1:0]   w_corner;
   logic [gws_pkg::COLS_REG_W-1:0] cols_reg;
   logic [gws_pkg::ROWS_REG_W-1:0] rows_reg;
   logic [15:0] upper_line [LINE_DEPTH];
   logic [15:0] middle_line [LINE_DEPTH];
   logic [15:0] window [gws_pkg::TAPS];
   int unsigned col_pos;
   int unsigned row_pos;
   logic [25:0] pixels_out;
   smoothed_pixel_type awaited_pixels [$];
   int unsigned failures;

   function new();
      w_center = gws_pkg::RESET_WEIGHT_CENTER;
      w_side   = gws_pkg::RESET_WEIGHT_EDGE;
      w_corner = gws_pkg::RESET_WEIGHT_CORNER;
      cols_reg = gws_pkg::RESET_IMAGE_COLS;
      rows_reg = gws_pkg::RESET_IMAGE_ROWS;
      foreach (upper_line[k]) begin
         upper_line[k]  = '0;
         middle_line[k] = '0;
      end
      foreach (window[k]) window[k] = '0;
      col_pos    = 0;
      row_pos    = 0;
      pixels_out = '0;
      failures   = 0;
   endfunction

   function void configure(logic [gws_pkg::CSR_INDEX_W-1:0] index,
                           logic [gws_pkg::WEIGHT_W-1:0] data);
      case (index)
         gws_pkg::REG_WEIGHT_CENTER: w_center = data;
         gws_pkg::REG_WEIGHT_EDGE:   w_side   = data;
         gws_pkg::REG_WEIGHT_CORNER: w_corner = data;
         gws_pkg::REG_IMAGE_COLS:    cols_reg = data[gws_pkg::COLS_REG_W-1:0];
         gws_pkg::REG_IMAGE_ROWS:    rows_reg = data[gws_pkg::ROWS_REG_W-1:0];
         default: ;
      endcase
   endfunction

   // one accepted request word; returns 1 when it completes the final pixel
   function bit take_word(logic command, logic [15:0] sample_in);
      int unsigned ncols, nrows, idx, j, i, ccol, crow;
      logic [15:0] s;
      bit top, bottom, left, right, last;
      logic [63:0] acc, q;
      logic [gws_pkg::WEIGHT_W-1:0] w;
      int r, c, ring;
      smoothed_pixel_type px;
      // out-of-range geometry is clamped rather than rejected
      ncols = (cols_reg == 0) ? 1 : ((cols_reg > LINE_DEPTH) ? LINE_DEPTH : cols_reg);
      nrows = (rows_reg == 0) ? 1 : rows_reg;
      s     = (command == gws_pkg::CMD_FLUSH) ? 16'd0 : sample_in;
      idx   = (col_pos < LINE_DEPTH) ? col_pos : LINE_DEPTH - 1;
      j     = col_pos;
      i     = row_pos;
      last  = 1'b0;

      for (r = 0; r < 3; r++) begin
         window[r*3]   = window[r*3+1];
         window[r*3+1] = window[r*3+2];
      end
      window[2]        = upper_line[idx];
      window[5]        = middle_line[idx];
      window[8]        = s;
      upper_line[idx]  = middle_line[idx];
      middle_line[idx] = s;

      if (col_pos + 1 >= ncols) begin
         col_pos = 0;
         row_pos++;
      end else begin
         col_pos++;
      end

      if ((j == 0 && i >= 2) || (j != 0 && i >= 1)) begin
         ccol   = (j == 0) ? ncols - 1 : j - 1;
         crow   = (j == 0) ? i - 2 : i - 1;
         top    = crow > 0;
         bottom = crow + 1 < nrows;
         left   = ccol > 0;
         right  = ccol + 1 < ncols;
         last   = (crow + 1 >= nrows) && (ccol + 1 >= ncols);
         acc    = '0;
         for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
               if (!((r == 0 && !top) || (r == 2 && !bottom) ||
                     (c == 0 && !left) || (c == 2 && !right))) begin
                  ring = (r != 1) + (c != 1);
                  w = (ring == 0) ? w_center : ((ring == 1) ? w_side : w_corner);
                  acc += {48'd0, window[r*3+c]} * {44'd0, w};
               end
            end
         end
         q = acc >> 16;
         px.value      = (q > 64'd65535) ? 16'hFFFF : q[15:0];
         px.saturated  = q > 64'd65535;
         px.last_pixel = last;
         awaited_pixels = {awaited_pixels, px};
         pixels_out = pixels_out + 26'd1;
         if (last) begin
            col_pos    = 0;
            row_pos    = 0;
            pixels_out = '0;
         end
      end
      return last;
   endfunction

   function int unsigned outstanding();
      return awaited_pixels.size();
   endfunction

   function void check_pixel(logic [15:0] value, logic saturated, logic last_pixel);
      smoothed_pixel_type exp_px;
      if (awaited_pixels.size() == 0) begin
         $display("%0t response word with nothing awaited: expected none, actual value %0d",
                  $time, value);
         failures++;
         return;
      end
      exp_px = awaited_pixels.pop_front();
      if (value !== exp_px.value) begin
         $display("%0t smoothed_value mismatch: expected %0d, actual %0d",
                  $time, exp_px.value, value);
         failures++;
      end
      if (saturated !== exp_px.saturated) begin
         $display("%0t saturated mismatch: expected %0b, actual %0b",
                  $time, exp_px.saturated, saturated);
         failures++;
      end
      if (last_pixel !== exp_px.last_pixel) begin
         $display("%0t last_pixel mismatch: expected %0b, actual %0b",
                  $time, exp_px.last_pixel, last_pixel);
         failures++;
      end
   endfunction
endclass

module gaussian_window_smoother_test;
   import gws_pkg::*;

   // cycles with no word moving on either channel before the run is abandoned
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 1650;
   // width the clamped image is narrowed to in its second pass
   localparam int CUT_COLS       = 40;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_command;
   logic [SAMPLE_W-1:0]    req_sample_value;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_smoothed_value;
   logic                   rsp_saturated;
   logic                   rsp_last_pixel;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WEIGHT_W-1:0]    csr_write_data;

   pixel_scoreboard board = new();

   bit               calm;          // no idling on either side while set
   int unsigned      words_sent;
   int unsigned      cur_cols = 1024;
   int unsigned      stuck;
   int               stall_left;
   logic [WEIGHT_W-1:0] next_center, next_side, next_corner;
   request_word_type scripted_words [$];

   gaussian_window_smoother #(
      .MAX_COLS(LINE_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_sample_value   (req_sample_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_saturated      (rsp_saturated),
      .rsp_last_pixel     (rsp_last_pixel),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // idle length: busy_pct percent of the time none, else mostly short, rarely long
   function automatic int pick_gap(int busy_pct);
      int roll;
      if (calm) return 0;
      if ($urandom_range(0, 99) < busy_pct) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 75) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned cols_in_effect(int unsigned v);
      if (v == 0) return 1;
      if (v > LINE_DEPTH) return LINE_DEPTH;
      return v;
   endfunction

   // weights: mostly near the usual sigma range, with the extremes now and then
   function automatic logic [WEIGHT_W-1:0] pick_weight();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 20'($urandom_range(0, 131071));
      if (roll < 75) return '0;
      if (roll < 90) return 20'hFFFFF;
      return 20'($urandom);
   endfunction

   // response side: check each accepted word, then choose the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_pixel(rsp_smoothed_value, rsp_saturated, rsp_last_pixel);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = pick_gap(85);
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // watchdog on forward progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck <= 0;
      end else if (stuck >= WATCHDOG_LIMIT) begin
         $display("%0t no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         stuck <= stuck + 1;
      end
   end

   // offer one request word and hold it until taken; called right after an edge
   task automatic send_word(logic command, logic [15:0] sample, output bit last);
      int gap;
      gap = pick_gap(70);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= command;
      req_sample_value <= sample;
      do @(posedge clock); while (!req_ready);
      last = board.take_word(command, sample);
      words_sent++;
   endtask

   // sender stops until every awaited pixel is back and the pipe has run dry
   task automatic wait_quiet();
      int settled;
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      // words that make no pixel may still be inside; ready must stay up a while
      settled = 0;
      while (settled < 12) begin
         @(posedge clock);
         settled = rsp_ready ? settled + 1 : 0;
      end
   endtask

   // enable stays high across back-to-back writes; csr_done drops it
   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [WEIGHT_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      board.configure(index, data);
      if (index == REG_IMAGE_COLS) cur_cols = cols_in_effect(data[COLS_REG_W-1:0]);
   endtask

   task automatic csr_done();
      csr_write_enable <= 1'b0;
   endtask

   // one image: pixels words of content, then drain until the final pixel is out
   task automatic run_image(int unsigned pixels, int shrink_at);
      int unsigned      n;
      bit               done;
      logic             command;
      logic [15:0]      sample;
      request_word_type w;
      n    = 0;
      done = 1'b0;
      while (!done) begin
         if (n == shrink_at) begin
            // geometry shrunk mid-image: the image ends early at the new bounds
            wait_quiet();
            csr_write(REG_IMAGE_ROWS, 20'($urandom_range(1, 3)));
            if ($urandom_range(0, 1) == 1)
               csr_write(REG_IMAGE_COLS, 20'($urandom_range(1, cur_cols)));
            csr_done();
         end else if (!calm && $urandom_range(0, 149) == 0) begin
            wait_quiet();
         end
         if (scripted_words.size() > 0) begin
            w       = scripted_words.pop_front();
            command = w.command;
            sample  = w.sample;
         end else begin
            sample = 16'($urandom);
            if (n < pixels)
               // a stray flush inside the image is just a zero sample
               command = ($urandom_range(0, 19) == 0) ? CMD_FLUSH : CMD_SAMPLE;
            else
               // a sample while draining only fills the padding row
               command = ($urandom_range(0, 4) == 0) ? CMD_SAMPLE : CMD_FLUSH;
         end
         send_word(command, sample, done);
         n++;
      end
      scripted_words.delete();
   endtask

   // idle the block, load the weights and a geometry, then stream one image
   task automatic start_image(int unsigned cols_val, int unsigned rows_val, int shrink_at);
      wait_quiet();
      csr_write(REG_WEIGHT_CENTER, next_center);
      csr_write(REG_WEIGHT_EDGE, next_side);
      csr_write(REG_WEIGHT_CORNER, next_corner);
      csr_write(REG_IMAGE_COLS, 20'(cols_val));
      csr_write(REG_IMAGE_ROWS, 20'(rows_val));
      csr_done();
      run_image(cols_in_effect(cols_val) * ((rows_val == 0) ? 1 : rows_val), shrink_at);
   endtask

   initial begin
      int unsigned c, r;
      int          s, roll;
      bit          done;

      req_valid        <= 1'b0;
      req_command      <= CMD_SAMPLE;
      req_sample_value <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= REG_WEIGHT_CENTER;
      csr_write_data   <= '0;
      reset            <= 1'b1;
      calm             = 1'b0;
      words_sent       = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default weights over a 3x2 image with extreme samples
      next_center = RESET_WEIGHT_CENTER;
      next_side   = RESET_WEIGHT_EDGE;
      next_corner = RESET_WEIGHT_CORNER;
      scripted_words = '{'{CMD_SAMPLE, 16'h0000}, '{CMD_SAMPLE, 16'hFFFF},
                         '{CMD_SAMPLE, 16'h8000}, '{CMD_SAMPLE, 16'h0001},
                         '{CMD_SAMPLE, 16'h7FFF}, '{CMD_SAMPLE, 16'hFFFF},
                         '{CMD_FLUSH,  16'hA5A5}, '{CMD_FLUSH,  16'h5A5A},
                         '{CMD_FLUSH,  16'hFFFF}, '{CMD_FLUSH,  16'h0000}};
      start_image(3, 2, -1);

      // largest weights on a single pixel: the sum must saturate
      next_center = 20'hFFFFF;
      next_side   = 20'hFFFFF;
      next_corner = 20'hFFFFF;
      scripted_words = '{'{CMD_SAMPLE, 16'hFFFF}, '{CMD_FLUSH, 16'h1234},
                         '{CMD_FLUSH, 16'h0000}};
      start_image(1, 1, -1);

      // zero weights give zero whatever the samples
      next_center = '0;
      next_side   = '0;
      next_corner = '0;
      scripted_words = '{'{CMD_SAMPLE, 16'hFFFF}, '{CMD_SAMPLE, 16'hFFFF},
                         '{CMD_FLUSH, 16'hFFFF}, '{CMD_FLUSH, 16'hFFFF},
                         '{CMD_FLUSH, 16'hFFFF}};
      start_image(2, 1, -1);

      // zero geometry acts as 1x1, unit centre weight, sample sent while draining
      next_center = 20'h10000;
      scripted_words = '{'{CMD_SAMPLE, 16'd12345}, '{CMD_SAMPLE, 16'hFFFF},
                         '{CMD_FLUSH, 16'h0000}};
      start_image(0, 0, -1);

      // an over-wide width clamps to the widest row, sent with no idling;
      // narrowing the width early in the second pass ends the image there
      calm = 1'b1;
      wait_quiet();
      csr_write(REG_WEIGHT_CENTER, pick_weight());
      csr_write(REG_WEIGHT_EDGE, pick_weight());
      csr_write(REG_WEIGHT_CORNER, pick_weight());
      csr_write(REG_IMAGE_COLS, 20'd2047);
      csr_write(REG_IMAGE_ROWS, 20'd0);
      csr_done();
      for (int n = 0; n < LINE_DEPTH + CUT_COLS; n++) begin
         send_word(CMD_SAMPLE, 16'($urandom), done);
      end
      wait_quiet();
      csr_write(REG_IMAGE_COLS, 20'(CUT_COLS));
      csr_done();
      done = 1'b0;
      while (!done) begin
         send_word(CMD_FLUSH, 16'($urandom), done);
      end
      calm = 1'b0;

      // tallest image, cut short by shrinking the geometry in the middle
      next_center = pick_weight();
      next_side   = pick_weight();
      next_corner = pick_weight();
      start_image(3, 65535, 7);

      while (words_sent < RANDOM_WORDS) begin
         calm        = ($urandom_range(0, 4) == 0);
         next_center = pick_weight();
         next_side   = pick_weight();
         next_corner = pick_weight();
         roll = $urandom_range(0, 99);
         if (roll < 70)      c = $urandom_range(1, 6);
         else if (roll < 88) c = $urandom_range(7, 24);
         else                c = 0;
         roll = $urandom_range(0, 99);
         if (roll < 80)      r = $urandom_range(1, 5);
         else if (roll < 90) r = 0;
         else                r = $urandom_range(6, 12);
         s = -1;
         if (r >= 4 && $urandom_range(0, 3) == 0)
            s = 2 * cols_in_effect(c) + $urandom_range(0, cols_in_effect(c) - 1);
         start_image(c, r, s);
      end

      calm = 1'b0;
      wait_quiet();
      if (board.failures == 0 && board.outstanding() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
